[rtl/circular_buffer_deque_core_assert.svh]
// ---------------------------------------------------------------------------
// deque core assertion macros
// shared property forms for the deque checks, sampled on clk, off in reset
// ---------------------------------------------------------------------------
`ifndef CIRCULAR_BUFFER_DEQUE_CORE_ASSERT_SVH
`define CIRCULAR_BUFFER_DEQUE_CORE_ASSERT_SVH

// condition holds at every edge out of reset
`define CBD_ASSERT_HOLDS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("deque invariant violated");

// consequent holds in the same cycle as the antecedent
`define CBD_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deque result check failed");

`endif

[rtl/cbd_pkg.sv]
// ---------------------------------------------------------------------------
// cbd_pkg
// shared types and constants of the deque core
// ---------------------------------------------------------------------------
package cbd_pkg;

	localparam int DEPTH_DEF   = 256;
	localparam int DATA_W      = 32;
	localparam int CMD_W       = 2;
	localparam int STATUS_W    = 2;
	localparam int COUNT_W     = 9;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 2'd0,
		CMD_POP_FRONT  = 2'd1,
		CMD_PUSH_BACK  = 2'd2,
		CMD_POP_BACK   = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// word returned by a pop on an empty deque
	localparam logic [DATA_W-1:0] POP_EMPTY_VALUE = '1;

	// classified operation handed from front to back
	typedef struct packed {
		logic                wr;
		logic                rd;
		status_t             status;
		logic [COUNT_W-1:0]  count;
	} op_ctl_t;

endpackage

[rtl/cbd_req_if.sv]
// ---------------------------------------------------------------------------
// cbd_req_if
// request channel: one deque operation per word
// ---------------------------------------------------------------------------
interface cbd_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [cbd_pkg::CMD_W-1:0]            cmd;
	logic signed [cbd_pkg::DATA_W-1:0]    value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink (input valid, input cmd, input value, output ready);
endinterface

[rtl/cbd_rsp_if.sv]
// ---------------------------------------------------------------------------
// cbd_rsp_if
// response channel: one result word per operation
// ---------------------------------------------------------------------------
interface cbd_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [cbd_pkg::DATA_W-1:0]    popped_value;
	logic [cbd_pkg::STATUS_W-1:0]         status;
	logic [cbd_pkg::COUNT_W-1:0]          count;

	modport source (output valid, output popped_value, output status, output count,
		input ready);
	modport sink (input valid, input popped_value, input status, input count,
		output ready);
endinterface

[rtl/cbd_ram.sv]
// ---------------------------------------------------------------------------
// cbd_ram
// single port ram, registered read data held until the next read
// ---------------------------------------------------------------------------
module cbd_ram #(
	parameter int WIDTH = cbd_pkg::DATA_W,
	parameter int DEPTH = cbd_pkg::DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

[rtl/cbd_queue.sv]
// ---------------------------------------------------------------------------
// cbd_queue
// short fifo between the classifying front and the memory back
// ---------------------------------------------------------------------------
module cbd_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             push_ready,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             pop_valid
);

	localparam int QD = cbd_pkg::QUEUE_DEPTH;
	localparam int PW = (QD > 1) ? $clog2(QD) : 1;
	localparam int FW = $clog2(QD + 1);

	logic [WIDTH-1:0] slot_q [QD];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [FW-1:0]    fill_q;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (p == PW'(QD - 1)) ? '0 : p + PW'(1);
	endfunction

	assign push_ready = (fill_q != FW'(QD));
	assign pop_valid  = (fill_q != '0);
	assign dout       = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= ptr_next(wptr_q);
			end
			if (pop) begin
				rptr_q <= ptr_next(rptr_q);
			end
			if (push && !pop) begin
				fill_q <= fill_q + FW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - FW'(1);
			end
		end
	end

endmodule

[rtl/cbd_front.sv]
// ---------------------------------------------------------------------------
// cbd_front
// accepts operations, owns head and count, picks the store address
// ---------------------------------------------------------------------------
module cbd_front #(
	parameter int DEPTH = cbd_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                valid,
	input  logic [cbd_pkg::CMD_W-1:0]           cmd,
	input  logic [cbd_pkg::DATA_W-1:0]          value,
	output logic                                ready,
	input  logic                                q_ready,
	output logic                                q_push,
	output cbd_pkg::op_ctl_t                    ctl,
	output logic [$clog2(DEPTH)-1:0]            addr,
	output logic [cbd_pkg::DATA_W-1:0]          wdata,
	output logic [$clog2(DEPTH+1)-1:0]          cnt
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	logic [AW-1:0] head_q, head_n;
	logic [CW-1:0] cnt_q, cnt_n;
	logic [SW-1:0] sum_back, sum_last;
	logic [AW-1:0] back_pos, last_pos, head_dec, head_inc;
	logic          full, empty, accept;
	cbd_pkg::cmd_t op;

	assign op     = cbd_pkg::cmd_t'(cmd);
	assign ready  = q_ready;
	assign accept = valid && q_ready;
	assign q_push = accept;
	assign wdata  = value;
	assign cnt    = cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);

	// head + count and head + count - 1, wrapped by one compare and subtract
	assign sum_back = SW'(head_q) + SW'(cnt_q);
	assign sum_last = sum_back - SW'(1);
	assign back_pos = (sum_back >= SW'(DEPTH)) ? AW'(sum_back - SW'(DEPTH)) : AW'(sum_back);
	assign last_pos = (sum_last >= SW'(DEPTH)) ? AW'(sum_last - SW'(DEPTH)) : AW'(sum_last);
	assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
	assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);

	always_comb begin
		head_n     = head_q;
		cnt_n      = cnt_q;
		addr       = head_q;
		ctl.wr     = 1'b0;
		ctl.rd     = 1'b0;
		ctl.status = cbd_pkg::ST_OK;
		unique case (op)
			cbd_pkg::CMD_PUSH_FRONT: begin
				if (full) begin
					ctl.status = cbd_pkg::ST_FULL;
				end else begin
					ctl.wr = 1'b1;
					head_n = head_dec;
					addr   = head_dec;
					cnt_n  = cnt_q + CW'(1);
				end
			end
			cbd_pkg::CMD_PUSH_BACK: begin
				if (full) begin
					ctl.status = cbd_pkg::ST_FULL;
				end else begin
					ctl.wr = 1'b1;
					addr   = back_pos;
					cnt_n  = cnt_q + CW'(1);
				end
			end
			cbd_pkg::CMD_POP_FRONT: begin
				if (empty) begin
					ctl.status = cbd_pkg::ST_EMPTY;
				end else begin
					ctl.rd = 1'b1;
					addr   = head_q;
					head_n = head_inc;
					cnt_n  = cnt_q - CW'(1);
				end
			end
			cbd_pkg::CMD_POP_BACK: begin
				if (empty) begin
					ctl.status = cbd_pkg::ST_EMPTY;
				end else begin
					ctl.rd = 1'b1;
					addr   = last_pos;
					cnt_n  = cnt_q - CW'(1);
				end
			end
		endcase
		ctl.count = cbd_pkg::COUNT_W'(cnt_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q  <= '0;
		end else if (accept) begin
			head_q <= head_n;
			cnt_q  <= cnt_n;
		end
	end

endmodule

[rtl/cbd_back.sv]
// ---------------------------------------------------------------------------
// cbd_back
// carries queued operations out on the element store, holds the result word
// ---------------------------------------------------------------------------
module cbd_back #(
	parameter int DEPTH = cbd_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_valid,
	output logic                                q_pop,
	input  cbd_pkg::op_ctl_t                    ctl,
	input  logic [$clog2(DEPTH)-1:0]            addr,
	input  logic [cbd_pkg::DATA_W-1:0]          wdata,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output logic [cbd_pkg::DATA_W-1:0]          popped_value,
	output logic [cbd_pkg::STATUS_W-1:0]        status,
	output logic [cbd_pkg::COUNT_W-1:0]         count
);

	logic                          issue;
	logic                          vld_s2;
	logic                          rd_s2;
	cbd_pkg::status_t              status_s2;
	logic [cbd_pkg::COUNT_W-1:0]   count_s2;
	logic [cbd_pkg::DATA_W-1:0]    rdata;

	// issue only into a free or emptying result slot, so read data holds
	assign issue = q_valid && (!vld_s2 || rsp_ready);
	assign q_pop = issue;

	cbd_ram #(
		.WIDTH (cbd_pkg::DATA_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (issue && ctl.wr),
		.re    (issue && ctl.rd),
		.addr  (addr),
		.wdata (wdata),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (issue) begin
			vld_s2 <= 1'b1;
		end else if (rsp_ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_s2     <= ctl.rd;
			status_s2 <= ctl.status;
			count_s2  <= ctl.count;
		end
	end

	always_comb begin
		if (rd_s2) begin
			popped_value = rdata;
		end else if (status_s2 == cbd_pkg::ST_EMPTY) begin
			popped_value = cbd_pkg::POP_EMPTY_VALUE;
		end else begin
			popped_value = '0;
		end
	end

	assign rsp_valid = vld_s2;
	assign status    = status_s2;
	assign count     = count_s2;

endmodule

[rtl/circular_buffer_deque_core.sv]
// ---------------------------------------------------------------------------
// circular_buffer_deque_core
// fixed capacity double ended queue held in a circular element store
// ---------------------------------------------------------------------------
//  channel  dir  word fields
//  -------  ---  ----------------------------------------------
//  req      in   cmd[1:0], value[31:0] signed
//  rsp      out  popped_value[31:0] signed, status[1:0], count[8:0]
//
//  one word per cycle sustained in both directions while rsp.ready stays high
//  path from req accept to rsp valid: queue slot, then ram read
//  rate is set by the single port store, one access per operation
//  reset clears head, count and valid flags; the store needs no clearing pass
//  a stalled rsp fills the two entry queue, then req.ready drops
// ---------------------------------------------------------------------------
`include "circular_buffer_deque_core_assert.svh"

module circular_buffer_deque_core #(
	parameter int DEPTH = cbd_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	cbd_req_if.sink       req,
	cbd_rsp_if.source     rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int CTL_W = $bits(cbd_pkg::op_ctl_t);
	// queue word: control, store address, push data
	localparam int QW = CTL_W + AW + cbd_pkg::DATA_W;

	// front side
	logic                          q_push, q_ready;
	cbd_pkg::op_ctl_t              f_ctl;
	logic [AW-1:0]                 f_addr;
	logic [cbd_pkg::DATA_W-1:0]    f_wdata;
	logic [CW-1:0]                 f_cnt;

	// back side
	logic                          q_pop, q_valid;
	logic [QW-1:0]                 q_dout;
	cbd_pkg::op_ctl_t              b_ctl;
	logic [AW-1:0]                 b_addr;
	logic [cbd_pkg::DATA_W-1:0]    b_wdata;
	logic [cbd_pkg::DATA_W-1:0]    b_popped;

	// front: classify, decide full or empty, move head and count
	cbd_front #(
		.DEPTH (DEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid   (req.valid),
		.cmd     (req.cmd),
		.value   (req.value),
		.ready   (req.ready),
		.q_ready (q_ready),
		.q_push  (q_push),
		.ctl     (f_ctl),
		.addr    (f_addr),
		.wdata   (f_wdata),
		.cnt     (f_cnt)
	);

	// decoupling queue, keeps operations in order
	cbd_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.din        ({f_ctl, f_addr, f_wdata}),
		.push_ready (q_ready),
		.pop        (q_pop),
		.dout       (q_dout),
		.pop_valid  (q_valid)
	);

	assign {b_ctl, b_addr, b_wdata} = q_dout;

	// back: store access and result register
	cbd_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.ctl          (b_ctl),
		.addr         (b_addr),
		.wdata        (b_wdata),
		.rsp_valid    (rsp.valid),
		.rsp_ready    (rsp.ready),
		.popped_value (b_popped),
		.status       (rsp.status),
		.count        (rsp.count)
	);

	assign rsp.popped_value = signed'(b_popped);

	// front count never passes capacity
	`CBD_ASSERT_HOLDS(a_cnt_bound, f_cnt <= CW'(DEPTH))
	// an empty pop reports no elements and the all ones word
	`CBD_ASSERT_IMPLIES(a_empty_rsp, rsp.valid && rsp.status == cbd_pkg::ST_EMPTY,
		rsp.count == '0 && rsp.popped_value == signed'(cbd_pkg::POP_EMPTY_VALUE))
	// a rejected push reports a full deque and a zero word
	`CBD_ASSERT_IMPLIES(a_full_rsp, rsp.valid && rsp.status == cbd_pkg::ST_FULL,
		rsp.count == cbd_pkg::COUNT_W'(DEPTH) && rsp.popped_value == '0)

endmodule
